>>> rtl/rdqd_pkg.sv
// Shared types, constants and lookup table for the rotary dial decoder.
package rdqd_pkg;

  localparam int COUNT_WIDTH = 32;
  localparam logic [COUNT_WIDTH-1:0] CNT_ONE = COUNT_WIDTH'(1);

  localparam int REG_ADDR_W = 3;

  // register index, taken from paddr[2]
  localparam logic REG_DEBOUNCE = 1'b0;
  localparam logic REG_STEPS    = 1'b1;

  localparam logic [7:0] DEBOUNCE_RESET = 8'd20;
  localparam logic [3:0] STEPS_RESET    = 4'd4;

  typedef enum logic [1:0] {
    DIR_NONE = 2'd0,
    DIR_CW   = 2'd1,
    DIR_CCW  = 2'd2
  } dir_t;

  typedef struct packed {
    logic [7:0] debounce_ms;
    logic [3:0] steps_per_detent;
  } cfg_t;

  // indexed by {prior_phase, phase}
  localparam logic signed [1:0] STEP_TABLE [0:15] = '{
     2'sd0,  2'sd1, -2'sd1,  2'sd0,
    -2'sd1,  2'sd0,  2'sd0,  2'sd1,
     2'sd1,  2'sd0,  2'sd0, -2'sd1,
     2'sd0, -2'sd1,  2'sd1,  2'sd0
  };

endpackage

>>> rtl/rdqd_if.sv
// Valid/ready channel interfaces for pin samples and decoder results.
interface rdqd_sample_if;
  logic        valid;
  logic        ready;
  logic        dial_ccw_level;
  logic        dial_cw_level;
  logic        button_level;
  logic [31:0] now_ms;

  modport source (output valid, dial_ccw_level, dial_cw_level, button_level, now_ms,
                  input ready);
  modport sink   (input valid, dial_ccw_level, dial_cw_level, button_level, now_ms,
                  output ready);
endinterface

interface rdqd_result_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] position;
  logic [31:0]        cw_detents;
  logic [31:0]        ccw_detents;
  logic [31:0]        presses;
  logic [1:0]         last_direction;
  logic [1:0]         phase_now;
  logic               cw_pin_active;
  logic               ccw_pin_active;
  logic               button_held;

  modport source (output valid, position, cw_detents, ccw_detents, presses,
                  last_direction, phase_now, cw_pin_active, ccw_pin_active,
                  button_held,
                  input ready);
  modport sink   (input valid, position, cw_detents, ccw_detents, presses,
                  last_direction, phase_now, cw_pin_active, ccw_pin_active,
                  button_held,
                  output ready);
endinterface

>>> rtl/rdqd_cfg.sv
// APB register file: debounce time and steps per detent.
module rdqd_cfg (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [rdqd_pkg::REG_ADDR_W-1:0] paddr,
  input  logic [31:0]                    pwdata,
  output logic [31:0]                    prdata,
  output logic                           pready,
  output rdqd_pkg::cfg_t                 cfg
);

  logic reg_sel;
  logic wr_en;

  assign pready  = 1'b1;
  assign reg_sel = paddr[2];
  assign wr_en   = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.debounce_ms      <= rdqd_pkg::DEBOUNCE_RESET;
      cfg.steps_per_detent <= rdqd_pkg::STEPS_RESET;
    end else if (wr_en) begin
      case (reg_sel)
        rdqd_pkg::REG_DEBOUNCE: cfg.debounce_ms      <= pwdata[7:0];
        rdqd_pkg::REG_STEPS:    cfg.steps_per_detent <= pwdata[3:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_sel)
      rdqd_pkg::REG_DEBOUNCE: prdata = {24'd0, cfg.debounce_ms};
      rdqd_pkg::REG_STEPS:    prdata = {28'd0, cfg.steps_per_detent};
      default:                prdata = 32'd0;
    endcase
  end

endmodule

>>> rtl/rdqd_core.sv
// Sample register, quadrature/debounce update and result register.
module rdqd_core (
  input  logic                  clk,
  input  logic                  rst,
  input  rdqd_pkg::cfg_t        cfg,
  rdqd_sample_if.sink           sample,
  rdqd_result_if.source         result
);

  localparam int CW = rdqd_pkg::COUNT_WIDTH;

  // sample register
  logic        s1_valid;
  logic        s1_ccw;
  logic        s1_cw;
  logic        s1_btn;
  logic [31:0] s1_now;

  // decoder state
  logic                 primed, primed_next;
  logic [1:0]           prior_phase, prior_phase_next;
  logic signed [4:0]    step_accum, step_accum_next;
  logic [CW-1:0]        net_position, net_position_next;
  logic [CW-1:0]        cw_total, cw_total_next;
  logic [CW-1:0]        ccw_total, ccw_total_next;
  logic [CW-1:0]        press_total, press_total_next;
  rdqd_pkg::dir_t       dir_last, dir_last_next;
  logic                 button_stable, button_stable_next;
  logic [31:0]          edge_time, edge_time_next;

  logic                 adv;
  logic [1:0]           phase;
  logic                 pressed;
  logic signed [1:0]    delta;
  logic signed [5:0]    accum_sum;
  logic signed [5:0]    limit;
  logic signed [5:0]    neg_limit;
  logic                 cw_hit;
  logic                 ccw_hit;
  logic [31:0]          elapsed;
  logic                 btn_take;
  logic                 press_inc;

  assign adv          = s1_valid && (!result.valid || result.ready);
  assign sample.ready = !s1_valid || adv;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (sample.ready) begin
      s1_valid <= sample.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (sample.valid && sample.ready) begin
      s1_ccw <= sample.dial_ccw_level;
      s1_cw  <= sample.dial_cw_level;
      s1_btn <= sample.button_level;
      s1_now <= sample.now_ms;
    end
  end

  assign phase     = {~s1_ccw, ~s1_cw};
  assign pressed   = ~s1_btn;
  assign delta     = (phase != prior_phase) ? rdqd_pkg::STEP_TABLE[{prior_phase, phase}]
                                            : 2'sd0;
  assign accum_sum = {step_accum[4], step_accum} + {{4{delta[1]}}, delta};
  assign limit     = (cfg.steps_per_detent == 4'd0) ? 6'sd1
                                                    : $signed({2'b00, cfg.steps_per_detent});
  assign neg_limit = -limit;
  assign cw_hit    = accum_sum >= limit;
  assign ccw_hit   = accum_sum <= neg_limit;
  assign elapsed   = s1_now - edge_time;
  assign btn_take  = (pressed != button_stable) && (elapsed >= {24'd0, cfg.debounce_ms});
  assign press_inc = primed && btn_take && pressed;

  always_comb begin
    primed_next        = primed;
    prior_phase_next   = prior_phase;
    step_accum_next    = step_accum;
    net_position_next  = net_position;
    cw_total_next      = cw_total;
    ccw_total_next     = ccw_total;
    press_total_next   = press_total;
    dir_last_next      = dir_last;
    button_stable_next = button_stable;
    edge_time_next     = edge_time;
    if (!primed) begin
      // first sample only seeds phase, contact level and time
      primed_next        = 1'b1;
      prior_phase_next   = phase;
      button_stable_next = pressed;
      edge_time_next     = s1_now;
    end else begin
      prior_phase_next = phase;
      if (cw_hit) begin
        step_accum_next   = 5'sd0;
        net_position_next = net_position + rdqd_pkg::CNT_ONE;
        cw_total_next     = cw_total + rdqd_pkg::CNT_ONE;
        dir_last_next     = rdqd_pkg::DIR_CW;
      end else if (ccw_hit) begin
        step_accum_next   = 5'sd0;
        net_position_next = net_position - rdqd_pkg::CNT_ONE;
        ccw_total_next    = ccw_total + rdqd_pkg::CNT_ONE;
        dir_last_next     = rdqd_pkg::DIR_CCW;
      end else begin
        step_accum_next   = accum_sum[4:0];
      end
      if (btn_take) begin
        button_stable_next = pressed;
        edge_time_next     = s1_now;
      end
      if (press_inc) begin
        press_total_next = press_total + rdqd_pkg::CNT_ONE;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      primed        <= 1'b0;
      prior_phase   <= 2'd0;
      step_accum    <= 5'sd0;
      net_position  <= '0;
      cw_total      <= '0;
      ccw_total     <= '0;
      press_total   <= '0;
      dir_last      <= rdqd_pkg::DIR_NONE;
      button_stable <= 1'b0;
      edge_time     <= 32'd0;
    end else if (adv) begin
      primed        <= primed_next;
      prior_phase   <= prior_phase_next;
      step_accum    <= step_accum_next;
      net_position  <= net_position_next;
      cw_total      <= cw_total_next;
      ccw_total     <= ccw_total_next;
      press_total   <= press_total_next;
      dir_last      <= dir_last_next;
      button_stable <= button_stable_next;
      edge_time     <= edge_time_next;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      result.valid <= 1'b0;
    end else if (adv) begin
      result.valid <= 1'b1;
    end else if (result.ready) begin
      result.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      result.position       <= $signed(32'(net_position_next));
      result.cw_detents     <= 32'(cw_total_next);
      result.ccw_detents    <= 32'(ccw_total_next);
      result.presses        <= 32'(press_total_next);
      result.last_direction <= dir_last_next;
      result.phase_now      <= phase;
      result.cw_pin_active  <= phase[0];
      result.ccw_pin_active <= phase[1];
      result.button_held    <= button_stable_next;
    end
  end

`ifndef SYNTHESIS
  a_accum_clears_on_detent: assert property (@(posedge clk) disable iff (rst)
    (adv && primed && (cw_hit || ccw_hit)) |=> (step_accum == 5'sd0))
    else $error("step accumulator not cleared after detent");

  a_state_holds_when_idle: assert property (@(posedge clk) disable iff (rst)
    !adv |=> ($stable(cw_total) && $stable(ccw_total) && $stable(press_total)))
    else $error("decoder state changed without a beat");

  a_press_sets_held: assert property (@(posedge clk) disable iff (rst)
    (adv && press_inc) |=> button_stable)
    else $error("press counted without pressed level");

  a_accum_in_range: assert property (@(posedge clk) disable iff (rst)
    primed |-> (step_accum != -5'sd16))
    else $error("step accumulator out of range");
`endif

endmodule

>>> rtl/rotary_dial_quadrature_decoder.sv
// Top level of the rotary dial quadrature decoder with push contact debounce.
//
// Usage:
//   sample  - valid/ready sink, one beat per pin sample: active-low ccw and cw
//             dial pins, active-low push contact, millisecond timestamp.
//   result  - valid/ready source, exactly one beat per sample: position,
//             detent and press counts, last direction, current phase/pins
//             and the debounced contact level.
//   APB     - debounce_ms at 0x0, steps_per_detent at 0x4; write only while
//             the block is idle. pready is tied high.
// Pipeline: a sample goes into the sample register, its result into the
//   result register. Throughput: one beat per cycle while result.ready is
//   high; all state updates (table decode, accumulate, detent compare,
//   debounce compare) finish in the single stage between the two registers.
// Reset (rst, synchronous): counters, accumulator and direction clear, the
//   registers return to 20 ms and 4 steps; the first sample after reset only
//   seeds phase, contact level and time.
// Stall: while result.ready is low a result beat is held; one more sample
//   can be taken into the sample register, then sample.ready drops.
module rotary_dial_quadrature_decoder (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [rdqd_pkg::REG_ADDR_W-1:0] paddr,
  input  logic [31:0]                     pwdata,
  output logic [31:0]                     prdata,
  output logic                            pready,
  rdqd_sample_if.sink                     sample,
  rdqd_result_if.source                   result
);

  rdqd_pkg::cfg_t cfg;

  rdqd_cfg u_cfg (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  rdqd_core u_core (
    .clk    (clk),
    .rst    (rst),
    .cfg    (cfg),
    .sample (sample),
    .result (result)
  );

endmodule

>>> tb/rotary_dial_quadrature_decoder_tb.sv
// Self-checking testbench for the rotary dial decoder: directed rows, random walks, scoreboard.
`timescale 1ns / 1ps

module rotary_dial_quadrature_decoder_tb;

  // Run limit in cycles; the slowest legal run is far below this.
  localparam int CYCLE_LIMIT = 200000;
  // Length of the forced receiver hold-off used to back the block up.
  localparam int LONG_HOLD = 60;
  localparam int INTRO_ROWS = 19;

  // Quadrature order seen when turning clockwise: 0 -> 1 -> 3 -> 2 -> 0.
  // Counter-clockwise walks the same ring backwards.
  localparam logic [1:0] CW_NEXT [0:3]  = '{2'd1, 2'd3, 2'd0, 2'd2};
  localparam logic [1:0] CCW_NEXT [0:3] = '{2'd2, 2'd0, 2'd3, 2'd1};

  typedef enum int {RX_ALWAYS, RX_RANDOM, RX_PATTERN} rx_mode_t;

  // One decoder reading, field for field as the result channel carries it.
  typedef struct packed {
    logic signed [31:0] position;
    logic [31:0]        cw_detents;
    logic [31:0]        ccw_detents;
    logic [31:0]        presses;
    rdqd_pkg::dir_t     last_direction;
    logic [1:0]         phase_now;
    logic               cw_pin_active;
    logic               ccw_pin_active;
    logic               button_held;
  } dial_reading_t;

  // One pin sample to send. The phase is given in active-high form; the
  // pins themselves are driven active low. A pinned row carries a reading
  // typed in by hand that replaces the decoder model's answer.
  typedef struct packed {
    logic [1:0]    phase;
    logic          button_level;
    logic [31:0]   now_ms;
    logic          pinned;
    dial_reading_t want;
  } pin_sample_t;

  localparam dial_reading_t NO_WANT = '0;

  logic        clk;
  logic        rst;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [rdqd_pkg::REG_ADDR_W-1:0] paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;

  rdqd_sample_if sample_ch ();
  rdqd_result_if result_ch ();

  rotary_dial_quadrature_decoder uut (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .sample  (sample_ch),
    .result  (result_ch)
  );

  // ---------------------------------------------------------------------
  // Decoder model state: own copy of the registers and of the dial state.
  // ---------------------------------------------------------------------
  rdqd_pkg::cfg_t     dial_cfg = '{debounce_ms: rdqd_pkg::DEBOUNCE_RESET,
                                   steps_per_detent: rdqd_pkg::STEPS_RESET};
  logic               seeded = 1'b0;      // first sample after reset seen
  logic [1:0]         trk_phase = 2'd0;
  int                 step_sum = 0;       // signed transition accumulator
  logic signed [31:0] pos_count = '0;
  logic [31:0]        cw_tally = '0;
  logic [31:0]        ccw_tally = '0;
  logic [31:0]        press_tally = '0;
  rdqd_pkg::dir_t     dir_seen = rdqd_pkg::DIR_NONE;
  logic               held_level = 1'b0;  // debounced contact, 1 pressed
  logic [31:0]        held_since = '0;    // time of last accepted contact change

  // Stimulus and scoreboard storage.
  pin_sample_t   sample_q[$];           // samples waiting to be offered
  dial_reading_t pending_readings[$];   // readings owed by the block, oldest first
  pin_sample_t   intro_rows [0:INTRO_ROWS-1];
  int            mismatches = 0;
  int            cycle_count = 0;

  // Sender / receiver knobs, changed by the main sequence between phases.
  logic          gaps_on = 1'b1;
  rx_mode_t      rx_mode = RX_ALWAYS;
  logic          hold_req = 1'b0;

  // Set by the sender next to each offered beat, read by the scoreboard.
  logic          pin_on = 1'b0;
  dial_reading_t pin_want = NO_WANT;

  // Random walk state for the generator.
  logic [1:0]    walk_phase = 2'd0;
  logic [31:0]   walk_ms = '0;
  logic          walk_btn = 1'b1;
  logic          walk_cw = 1'b1;
  int            run_left = 0;

  // ---------------------------------------------------------------------
  // Clock, reset, watchdog
  // ---------------------------------------------------------------------
  initial clk = 1'b0;
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  // ---------------------------------------------------------------------
  // Decoder model: one pin sample in, one reading out.
  // ---------------------------------------------------------------------
  function automatic dial_reading_t decode_sample(input logic [1:0] ph,
                                                  input logic btn_level,
                                                  input logic [31:0] ms);
    dial_reading_t r;
    int            lim;
    logic [31:0]   elapsed;
    logic          pressed;
    pressed = ~btn_level;
    if (!seeded) begin
      // first sample only seeds phase, contact level and time
      trk_phase  = ph;
      held_level = pressed;
      held_since = ms;
      seeded     = 1'b1;
    end else begin
      // zero steps per detent behaves like one
      lim = (dial_cfg.steps_per_detent == 4'd0) ? 1 : int'(dial_cfg.steps_per_detent);
      if (ph != trk_phase) begin
        // neighbor on the ring counts +/-1; a jump across it counts nothing
        if (CW_NEXT[trk_phase] == ph) step_sum++;
        else if (CCW_NEXT[trk_phase] == ph) step_sum--;
        trk_phase = ph;
      end
      if (step_sum >= lim) begin
        pos_count++;
        cw_tally++;
        dir_seen = rdqd_pkg::DIR_CW;
        step_sum = 0;
      end
      if (step_sum <= -lim) begin
        pos_count--;
        ccw_tally++;
        dir_seen = rdqd_pkg::DIR_CCW;
        step_sum = 0;
      end
      elapsed = ms - held_since;   // wraps modulo 2^32
      if (pressed != held_level && elapsed >= 32'(dial_cfg.debounce_ms)) begin
        held_level = pressed;
        held_since = ms;
        if (pressed) press_tally++;
      end
    end
    r.position       = pos_count;
    r.cw_detents     = cw_tally;
    r.ccw_detents    = ccw_tally;
    r.presses        = press_tally;
    r.last_direction = dir_seen;
    r.phase_now      = ph;
    r.cw_pin_active  = ph[0];
    r.ccw_pin_active = ph[1];
    r.button_held    = held_level;
    return r;
  endfunction

  task automatic check_field(input string name, input logic [31:0] want,
                             input logic [31:0] got);
    if (got !== want) begin
      $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
      mismatches++;
    end
  endtask

  // ---------------------------------------------------------------------
  // Scoreboard. Sample side first, then result side, in one block so the
  // order within an edge is fixed. Both see pre-edge values.
  // ---------------------------------------------------------------------
  always @(posedge clk) begin : scoreboard
    dial_reading_t predicted;
    dial_reading_t oldest;
    if (!rst) begin
      if (sample_ch.valid && sample_ch.ready) begin
        predicted = decode_sample({~sample_ch.dial_ccw_level, ~sample_ch.dial_cw_level},
                                  sample_ch.button_level, sample_ch.now_ms);
        pending_readings.push_back(pin_on ? pin_want : predicted);
      end
      if (result_ch.valid && result_ch.ready) begin
        if (pending_readings.size() == 0) begin
          $error("result beat with no sample pending");
          mismatches++;
        end else begin
          oldest = pending_readings.pop_front();
          check_field("position", oldest.position, result_ch.position);
          check_field("cw_detents", oldest.cw_detents, result_ch.cw_detents);
          check_field("ccw_detents", oldest.ccw_detents, result_ch.ccw_detents);
          check_field("presses", oldest.presses, result_ch.presses);
          check_field("last_direction", 32'(oldest.last_direction),
                      32'(result_ch.last_direction));
          check_field("phase_now", 32'(oldest.phase_now), 32'(result_ch.phase_now));
          check_field("cw_pin_active", 32'(oldest.cw_pin_active),
                      32'(result_ch.cw_pin_active));
          check_field("ccw_pin_active", 32'(oldest.ccw_pin_active),
                      32'(result_ch.ccw_pin_active));
          check_field("button_held", 32'(oldest.button_held), 32'(result_ch.button_held));
        end
      end
    end
  end

  // ---------------------------------------------------------------------
  // Sender: offers the head of sample_q, in bursts with random gaps when
  // gaps_on is set. A beat leaves the queue at the edge that accepts it.
  // Inputs change only on the falling edge.
  // ---------------------------------------------------------------------
  initial begin : sender
    int gap_left;
    int burst_left;
    gap_left   = 0;
    burst_left = 0;
    sample_ch.valid          = 1'b0;
    sample_ch.dial_ccw_level = 1'b1;
    sample_ch.dial_cw_level  = 1'b1;
    sample_ch.button_level   = 1'b1;
    sample_ch.now_ms         = '0;
    forever begin
      @(posedge clk);
      if (sample_ch.valid && sample_ch.ready) begin
        void'(sample_q.pop_front());
        if (gaps_on) begin
          if (burst_left > 0) begin
            burst_left--;
          end else begin
            // mostly short gaps, now and then a long one
            gap_left   = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 20)
                                                      : $urandom_range(1, 4);
            burst_left = $urandom_range(0, 10);
          end
        end
      end
      @(negedge clk);
      if (gap_left > 0 || sample_q.size() == 0) begin
        if (gap_left > 0) gap_left--;
        // idle beat: payload is noise, the block must ignore it
        sample_ch.valid          = 1'b0;
        sample_ch.dial_ccw_level = 1'($urandom_range(0, 1));
        sample_ch.dial_cw_level  = 1'($urandom_range(0, 1));
        sample_ch.button_level   = 1'($urandom_range(0, 1));
        sample_ch.now_ms         = $urandom();
        pin_on                   = 1'b0;
      end else begin
        sample_ch.valid          = 1'b1;
        sample_ch.dial_ccw_level = ~sample_q[0].phase[1];
        sample_ch.dial_cw_level  = ~sample_q[0].phase[0];
        sample_ch.button_level   = sample_q[0].button_level;
        sample_ch.now_ms         = sample_q[0].now_ms;
        pin_on                   = sample_q[0].pinned;
        pin_want                 = sample_q[0].want;
      end
    end
  end

  // ---------------------------------------------------------------------
  // Receiver: ready follows rx_mode; a hold request forces ready low until a
  // countdown from LONG_HOLD, kept here, runs out, so the block backs up and stalls.
  // ---------------------------------------------------------------------
  initial begin : receiver
    int hold_left;
    int tick;
    hold_left = 0;
    tick      = 0;
    result_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      tick++;
      if (hold_req) begin
        hold_left = LONG_HOLD;
        hold_req  = 1'b0;
      end
      if (hold_left > 0) begin
        hold_left--;
        result_ch.ready = 1'b0;
      end else begin
        case (rx_mode)
          RX_ALWAYS: result_ch.ready = 1'b1;
          RX_RANDOM: result_ch.ready = ($urandom_range(0, 9) >= 4);
          default:   result_ch.ready = ((tick % 7) >= 3);
        endcase
      end
    end
  end

  // ---------------------------------------------------------------------
  // Config port: setup beat then access beat; model follows after the
  // write edge. Upper data bits carry noise the block must drop.
  // ---------------------------------------------------------------------
  task automatic apb_write(input logic reg_sel, input logic [31:0] value);
    logic [31:0] noisy;
    noisy = reg_sel == rdqd_pkg::REG_DEBOUNCE
            ? {24'($urandom_range(0, 16777215)), value[7:0]}
            : {24'($urandom_range(0, 16777215)), 4'($urandom), value[3:0]};
    @(negedge clk);
    psel    = 1'b1;
    penable = 1'b0;
    pwrite  = 1'b1;
    paddr   = {reg_sel, 2'b00};
    pwdata  = noisy;
    @(negedge clk);
    penable = 1'b1;
    do @(posedge clk); while (!pready);
    @(negedge clk);
    psel    = 1'b0;
    penable = 1'b0;
    pwrite  = 1'b0;
    if (reg_sel == rdqd_pkg::REG_DEBOUNCE) dial_cfg.debounce_ms = noisy[7:0];
    else dial_cfg.steps_per_detent = noisy[3:0];
  endtask

  // Wait until every queued sample went in and every reading came back.
  // Checked on the falling edge, once the sender and scoreboard have settled.
  task automatic wait_idle();
    while (sample_q.size() != 0 || pending_readings.size() != 0) @(negedge clk);
  endtask

  // ---------------------------------------------------------------------
  // Random walk: mostly runs of legal quadrature steps in one direction,
  // with dwell, jitter back, illegal jumps and noise mixed in. Time moves
  // in small steps so the contact bounces against the debounce window,
  // with occasional long jumps and jumps around the 32-bit wrap.
  // ---------------------------------------------------------------------
  task automatic queue_walk(input int count);
    pin_sample_t s;
    int          pick;
    for (int i = 0; i < count; i++) begin
      if (run_left == 0) begin
        walk_cw  = 1'($urandom_range(0, 1));
        run_left = $urandom_range(1, 40);
      end
      run_left--;
      pick = $urandom_range(0, 99);
      if (pick < 78)      walk_phase = walk_cw ? CW_NEXT[walk_phase] : CCW_NEXT[walk_phase];
      else if (pick < 88) walk_phase = walk_phase;                    // dwell
      else if (pick < 93) walk_phase = walk_cw ? CCW_NEXT[walk_phase]
                                               : CW_NEXT[walk_phase]; // jitter back
      else if (pick < 97) walk_phase = ~walk_phase;                   // illegal jump
      else                walk_phase = 2'($urandom_range(0, 3));      // noise
      pick = $urandom_range(0, 99);
      if (pick < 85)      walk_ms = walk_ms + $urandom_range(0, 12);
      else if (pick < 95) walk_ms = walk_ms + $urandom_range(13, 300);
      else if (pick < 98) walk_ms = $urandom();
      else                walk_ms = 32'hFFFF_FFF0 + $urandom_range(0, 31);
      if ($urandom_range(0, 9) == 0) walk_btn = ~walk_btn;
      s = '{phase: walk_phase, button_level: walk_btn, now_ms: walk_ms,
            pinned: 1'b0, want: NO_WANT};
      sample_q.push_back(s);
    end
  endtask

  // ---------------------------------------------------------------------
  // Main sequence
  // ---------------------------------------------------------------------
  initial begin : main_seq
    logic [7:0] debounce_set [0:3];
    logic [3:0] steps_set [0:3];
    debounce_set = '{8'd0, 8'd255, 8'd3, 8'd100};
    steps_set    = '{4'd1, 4'd15, 4'd0, 4'd2};

    rst     = 1'b1;
    psel    = 1'b0;
    penable = 1'b0;
    pwrite  = 1'b0;
    paddr   = '0;
    pwdata  = '0;

    // Directed rows under the reset register values (20 ms, 4 steps).
    // Phase is {ccw active, cw active}; button level 0 means pressed.
    intro_rows = '{
      // first sample: seeds phase 2 and a held contact, counts stay zero
      '{2'd2, 1'b0, 32'd100, 1'b1,
        '{32'sd0, 32'd0, 32'd0, 32'd0, rdqd_pkg::DIR_NONE, 2'd2, 1'b0, 1'b1, 1'b1}},
      // one full clockwise detent: 2 -> 0 -> 1 -> 3 -> 2
      '{2'd0, 1'b0, 32'd101, 1'b0, NO_WANT},
      '{2'd1, 1'b0, 32'd102, 1'b0, NO_WANT},
      '{2'd3, 1'b0, 32'd103, 1'b0, NO_WANT},
      '{2'd2, 1'b0, 32'd104, 1'b1,
        '{32'sd1, 32'd1, 32'd0, 32'd0, rdqd_pkg::DIR_CW, 2'd2, 1'b0, 1'b1, 1'b1}},
      // illegal jump 2 -> 1; release 10 ms after the seed is too early
      '{2'd1, 1'b1, 32'd110, 1'b0, NO_WANT},
      // release exactly at the debounce time is taken
      '{2'd1, 1'b1, 32'd120, 1'b0, NO_WANT},
      // counter-clockwise detent 1 -> 0 -> 2 -> 3 -> 1; press 5 ms in is
      // dropped, press 20 ms in counts
      '{2'd0, 1'b0, 32'd125, 1'b0, NO_WANT},
      '{2'd2, 1'b0, 32'd140, 1'b0, NO_WANT},
      '{2'd3, 1'b0, 32'd150, 1'b0, NO_WANT},
      '{2'd1, 1'b0, 32'd160, 1'b1,
        '{32'sd0, 32'd1, 32'd1, 32'd1, rdqd_pkg::DIR_CCW, 2'd1, 1'b1, 1'b0, 1'b1}},
      // illegal jump 1 -> 2
      '{2'd2, 1'b0, 32'd170, 1'b0, NO_WANT},
      // release just before the time wraps, then presses across the wrap:
      // 19 ms elapsed is dropped, 20 ms is taken
      '{2'd2, 1'b1, 32'hFFFF_FFF0, 1'b0, NO_WANT},
      '{2'd2, 1'b0, 32'hFFFF_FFFF, 1'b0, NO_WANT},
      '{2'd2, 1'b0, 32'h0000_0003, 1'b0, NO_WANT},
      '{2'd2, 1'b0, 32'h0000_0004, 1'b0, NO_WANT},
      // time at zero, then illegal jump 3 -> 0
      '{2'd3, 1'b0, 32'h0000_0000, 1'b0, NO_WANT},
      '{2'd0, 1'b0, 32'h0000_0000, 1'b0, NO_WANT},
      '{2'd1, 1'b1, 32'h0000_0005, 1'b0, NO_WANT}
    };

    repeat (3) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    gaps_on = 1'b0;
    rx_mode = RX_ALWAYS;
    foreach (intro_rows[i]) sample_q.push_back(intro_rows[i]);
    wait_idle();

    walk_phase = 2'd1;
    walk_ms    = 32'd5;
    walk_btn   = 1'b1;

    // random beats on reset registers, both sides idling
    gaps_on = 1'b1;
    rx_mode = RX_RANDOM;
    queue_walk(60);
    wait_idle();

    // back-pressure: receiver holds off while the sender keeps offering
    gaps_on = 1'b0;
    rx_mode = RX_ALWAYS;
    queue_walk(24);
    hold_req = 1'b1;
    wait_idle();

    // register sweeps; the sender has paused and all readings are back
    for (int p = 0; p < 4; p++) begin
      apb_write(rdqd_pkg::REG_DEBOUNCE, 32'(debounce_set[p]));
      apb_write(rdqd_pkg::REG_STEPS, 32'(steps_set[p]));
      gaps_on = (p != 1);
      rx_mode = (p == 0) ? RX_PATTERN : (p == 1) ? RX_ALWAYS : RX_RANDOM;
      queue_walk(75);
      wait_idle();
    end

    // settle time for any stray beat from the two-stage pipe
    repeat (20) @(posedge clk);
    if (mismatches == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

>>> filelist.f
rtl/rdqd_pkg.sv
rtl/rdqd_if.sv
rtl/rdqd_cfg.sv
rtl/rdqd_core.sv
rtl/rotary_dial_quadrature_decoder.sv
tb/rotary_dial_quadrature_decoder_tb.sv
